// ----- src/sle_pkg.sv -----
// Shared types and codes for the sequential list engine.
// No dependencies; imported by the control unit and the top level.
package sle_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_BADPOS   = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] removed;
		logic [7:0]  found;
		logic [7:0]  length;
	} res_t;

endpackage

// ----- src/sle_store.sv -----
// Element store of the list: one write port and one read port, registered read data.
// No package dependencies.
module sle_store #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/sle_ctrl.sv -----
// Sequencer of the list engine: decodes each request, walks the store one entry per
// cycle for insert, delete and find, and keeps the element count. Uses sle_pkg.
module sle_ctrl #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int CW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    func,
	input  logic [7:0]    position,
	input  logic [31:0]   value,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [31:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [31:0]   mem_rdata,
	output logic          res_valid,
	input  logic          res_take,
	output sle_pkg::res_t res
);
	import sle_pkg::*;

	localparam int PW = (CW > 8) ? CW : 8;

	state_t        state_q, state_d;
	op_t           op_in, op_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   val_q;
	logic [AW-1:0] pos0_q, rd_q, last_q, addr_s1;
	logic          scan_q, pend_s1;
	status_t       stat_q;
	logic [31:0]   removed_q;
	logic [7:0]    found_q;

	logic [PW-1:0] cnt_w, pos_w, pos_m1_w, cnt_m1_w, fnd_w;
	logic [AW-1:0] pos_m1, cnt_m1;
	logic          full, empty, bad_pos, match, accept;

	assign op_in  = op_t'(func);
	assign accept = req_valid && !req_stall;

	always_comb begin
		cnt_w    = PW'(cnt_q);
		pos_w    = PW'(position);
		pos_m1_w = pos_w - PW'(1);
		cnt_m1_w = cnt_w - PW'(1);
		pos_m1   = pos_m1_w[AW-1:0];
		cnt_m1   = cnt_m1_w[AW-1:0];
		full     = cnt_w >= PW'(DEPTH);
		empty    = cnt_q == '0;
		bad_pos  = (pos_w == '0) || (pos_w > cnt_w);
		fnd_w    = PW'(addr_s1) + PW'(1);
		match    = pend_s1 && (op_q == OP_FIND) && (mem_rdata == val_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DONE;
					unique case (op_in)
						OP_APPEND: state_d = ST_DONE;
						OP_INSERT: if (!full && !bad_pos) state_d = ST_SHIFT;
						OP_DELETE: if (!empty && !bad_pos) state_d = ST_SHIFT;
						OP_FIND:   if (!empty) state_d = ST_SHIFT;
					endcase
				end
			end
			ST_SHIFT: begin
				if (match) begin
					state_d = ST_DONE;
				end else if (pend_s1 && !scan_q) begin
					state_d = (op_q == OP_INSERT) ? ST_PUT : ST_DONE;
				end
			end
			ST_PUT:  state_d = ST_DONE;
			ST_DONE: if (res_take) state_d = ST_IDLE;
		endcase
	end

	// Outputs: store write port, handshakes.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;
		req_stall = state_q != ST_IDLE;
		res_valid = state_q == ST_DONE;
		mem_raddr = rd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && op_in == OP_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_w[AW-1:0];
					mem_wdata = value;
				end
			end
			ST_SHIFT: begin
				// Insert moves each entry up by one, walking down from the tail.
				if (pend_s1 && op_q == OP_INSERT) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 + AW'(1);
				end
				// Delete moves each entry after the removed one down by one.
				if (pend_s1 && op_q == OP_DELETE && addr_s1 != pos0_q) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 - AW'(1);
				end
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos0_q;
				mem_wdata = val_q;
			end
			ST_DONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			scan_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= 1'b0;
			if (state_q == ST_IDLE && accept) begin
				scan_q <= state_d == ST_SHIFT;
				unique case (op_in)
					OP_APPEND: if (!full) cnt_q <= cnt_q + CW'(1);
					OP_INSERT: if (!full && !bad_pos) cnt_q <= cnt_q + CW'(1);
					OP_DELETE: if (!empty && !bad_pos) cnt_q <= cnt_q - CW'(1);
					OP_FIND:   ;
				endcase
			end else if (state_q == ST_SHIFT) begin
				if (state_d != ST_SHIFT) begin
					scan_q <= 1'b0;
				end else begin
					pend_s1 <= scan_q;
					if (scan_q && rd_q == last_q) begin
						scan_q <= 1'b0;
					end
				end
			end
		end
	end

	// Request and scan datapath; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			op_q      <= op_in;
			val_q     <= value;
			pos0_q    <= pos_m1;
			stat_q    <= STAT_OK;
			removed_q <= '0;
			found_q   <= '0;
			unique case (op_in)
				OP_APPEND: if (full) stat_q <= STAT_FULL;
				OP_INSERT: begin
					if (full) stat_q <= STAT_FULL;
					else if (bad_pos) stat_q <= STAT_BADPOS;
					rd_q   <= cnt_m1;
					last_q <= pos_m1;
				end
				OP_DELETE: begin
					if (empty) stat_q <= STAT_EMPTY;
					else if (bad_pos) stat_q <= STAT_BADPOS;
					rd_q   <= pos_m1;
					last_q <= cnt_m1;
				end
				OP_FIND: begin
					stat_q <= STAT_NOTFOUND;
					rd_q   <= '0;
					last_q <= cnt_m1;
				end
			endcase
		end else if (state_q == ST_SHIFT) begin
			addr_s1 <= rd_q;
			if (scan_q && rd_q != last_q) begin
				rd_q <= (op_q == OP_INSERT) ? rd_q - AW'(1) : rd_q + AW'(1);
			end
			if (pend_s1 && op_q == OP_DELETE && addr_s1 == pos0_q) begin
				removed_q <= mem_rdata;
			end
			if (match) begin
				stat_q  <= STAT_OK;
				found_q <= fnd_w[7:0];
			end
		end
	end

	assign res.status  = stat_q;
	assign res.removed = removed_q;
	assign res.found   = found_q;
	assign res.length  = cnt_w[7:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above capacity");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && scan_q) |-> (mem_waddr != mem_raddr))
		else $error("shift writes the entry being read");

	a_scan_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_q || pend_s1) |-> (state_q == ST_SHIFT))
		else $error("store walk outside the shift state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != ST_IDLE))
		else $error("accepted item left no work");

endmodule

// ----- src/sequential_list_engine_top.sv -----
// Top level of the sequential list engine: control unit, element store and the
// result register. Uses sle_pkg, sle_ctrl and sle_store.
//
// The engine keeps an ordered list of signed 32-bit words with append, insert, delete
// and find requests, one at a time. Append and every rejected request need no walk of the
// store. Insert at position p walks the entries from the tail down to p, then writes the
// new value; delete walks from p to the tail and find from the head to a match: the store
// has a single read port and a single write port, so the entry walk moves one element
// per cycle. A waiting result sits in its own register, so the next request is taken
// while it waits. The store needs no clearing after reset.
module sequential_list_engine_top #(
	parameter int DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [31:0] removed_value,
	output logic [7:0]         found_position,
	output logic [7:0]         list_length
);
	import sle_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;
	logic          res_valid, res_take, rsp_valid_q;
	res_t          res;

	sle_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.position  (position),
		.value     (value),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	sle_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			status         <= res.status;
			removed_value  <= res.removed;
			found_position <= res.found;
			list_length    <= res.length;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
